FILE: src/sdtq_pkg.sv
// types and constants shared by the sorted deadline timer queue
package sdtq_pkg;

  localparam int unsigned HANDLE_W    = 6;
  localparam int unsigned NUM_HANDLES = 64;
  localparam int unsigned TIME_IN_W   = 32;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned STATUS_W    = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_ADJUST = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_TICK   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE    = 3'd0,
    STAT_EXPIRED = 3'd1,
    STAT_NONE    = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_ABSENT  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_REMOVE,
    ST_TICK,
    ST_TICK_END,
    ST_RESP
  } state_e;

endpackage

FILE: src/sorted_deadline_timer_queue_top.sv
// sorted deadline timer queue: ordered timer list walked by a small sequencer
//
// Keeps up to DEPTH timers, named by 6-bit handles, in ascending expiry order in an
// order memory with one read and one write port that holds handle and expiry side by
// side. Add, delete and tick are each one linear walk over that memory; adjust is a
// removal walk followed by an insertion walk. A walk visits one entry per cycle, but
// a tick walk holds while the result side stalls. in_ready_o is high only while the
// sequencer is idle; one result per item, or one per expired timer on a tick, with
// last_o marking the final result. No clearing pass is needed after reset.
module sorted_deadline_timer_queue_top #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [sdtq_pkg::KIND_W-1:0]    kind_i,
  input  logic [sdtq_pkg::HANDLE_W-1:0]  handle_i,
  input  logic [sdtq_pkg::TIME_IN_W-1:0] expire_time_i,
  input  logic [sdtq_pkg::TIME_IN_W-1:0] now_time_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sdtq_pkg::STATUS_W-1:0]  status_o,
  output logic [sdtq_pkg::HANDLE_W-1:0]  expired_handle_o,
  output logic                           last_o
);
  import sdtq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [HANDLE_W-1:0]  hdl;
    logic [TIME_BITS-1:0] tm;
  } entry_t;

  // order memory
  entry_t            mem [DEPTH];
  entry_t            rd_q;
  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_waddr, mem_raddr;
  entry_t            mem_wdata;

  state_e                 state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [CntW-1:0]        j_q, j_d;
  logic [CntW-1:0]        n_q, n_d;
  logic                   found_q, found_d;
  logic                   pop_q, pop_d;
  logic                   pend_q, pend_d;
  logic [HANDLE_W-1:0]    pend_h_q, pend_h_d;
  status_e                rs_q, rs_d;
  logic [HANDLE_W-1:0]    rh_q, rh_d;
  logic [NUM_HANDLES-1:0] present_q, present_d;
  logic                   ov_q, ov_d;
  status_e                os_q, os_d;
  logic [HANDLE_W-1:0]    oh_q, oh_d;
  logic                   ol_q, ol_d;

  kind_e                  kind_q;
  logic [HANDLE_W-1:0]    hdl_q;
  logic [TIME_BITS-1:0]   exp_q, now_q;
  logic                   ld;

  logic                   can_emit;
  logic [CntW-1:0]        jm1, jm2, jp1, cm1, cm2, shift_at;
  entry_t                 new_e;

  assign can_emit  = !ov_q || out_ready_i;
  assign jm1       = j_q - 1'b1;
  assign jm2       = j_q - 2'd2;
  assign jp1       = j_q + 1'b1;
  assign cm1       = cnt_q - 1'b1;
  assign cm2       = cnt_q - 2'd2;
  assign shift_at  = j_q - n_q;
  assign new_e.hdl = hdl_q;
  assign new_e.tm  = exp_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      kind_q <= kind_e'(kind_i);
      hdl_q  <= handle_i;
      exp_q  <= TIME_BITS'(expire_time_i);
      now_q  <= TIME_BITS'(now_time_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      j_q       <= '0;
      n_q       <= '0;
      found_q   <= 1'b0;
      pop_q     <= 1'b0;
      pend_q    <= 1'b0;
      pend_h_q  <= '0;
      rs_q      <= STAT_DONE;
      rh_q      <= '0;
      present_q <= '0;
      ov_q      <= 1'b0;
      os_q      <= STAT_DONE;
      oh_q      <= '0;
      ol_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      j_q       <= j_d;
      n_q       <= n_d;
      found_q   <= found_d;
      pop_q     <= pop_d;
      pend_q    <= pend_d;
      pend_h_q  <= pend_h_d;
      rs_q      <= rs_d;
      rh_q      <= rh_d;
      present_q <= present_d;
      ov_q      <= ov_d;
      os_q      <= os_d;
      oh_q      <= oh_d;
      ol_q      <= ol_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    j_d       = j_q;
    n_d       = n_q;
    found_d   = found_q;
    pop_d     = pop_q;
    pend_d    = pend_q;
    pend_h_d  = pend_h_q;
    rs_d      = rs_q;
    rh_d      = rh_q;
    present_d = present_q;
    ov_d      = ov_q && !out_ready_i;
    os_d      = os_q;
    oh_d      = oh_q;
    ol_d      = ol_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = new_e;
    mem_re    = 1'b0;
    mem_raddr = '0;
    ld        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ld      = 1'b1;
          rh_d    = '0;
          j_d     = '0;
          n_d     = '0;
          found_d = 1'b0;
          pop_d   = 1'b1;
          pend_d  = 1'b0;
          unique case (kind_e'(kind_i))
            KIND_ADD: begin
              if (present_q[handle_i]) begin
                rs_d    = STAT_ABSENT;
                state_d = ST_RESP;
              end else if (cnt_q == CntW'(DEPTH)) begin
                rs_d    = STAT_FULL;
                state_d = ST_RESP;
              end else begin
                j_d = cnt_q;
                if (cnt_q == '0) begin
                  state_d = ST_INS_PUT;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = cm1[IdxW-1:0];
                  state_d   = ST_INS_CMP;
                end
              end
            end
            KIND_ADJUST, KIND_DELETE: begin
              if (!present_q[handle_i]) begin
                rs_d    = STAT_ABSENT;
                state_d = ST_RESP;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_d   = ST_REMOVE;
              end
            end
            KIND_TICK: begin
              if (cnt_q == '0) begin
                rs_d    = STAT_NONE;
                state_d = ST_RESP;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_d   = ST_TICK;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_INS_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = j_q[IdxW-1:0];
        if (rd_q.tm <= exp_q) begin
          mem_wdata        = new_e;
          cnt_d            = cnt_q + 1'b1;
          present_d[hdl_q] = 1'b1;
          rs_d             = STAT_DONE;
          state_d          = ST_RESP;
        end else begin
          mem_wdata = rd_q;
          j_d       = jm1;
          if (jm1 == '0) begin
            state_d = ST_INS_PUT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = jm2[IdxW-1:0];
          end
        end
      end

      ST_INS_PUT: begin
        mem_we           = 1'b1;
        mem_waddr        = j_q[IdxW-1:0];
        mem_wdata        = new_e;
        cnt_d            = cnt_q + 1'b1;
        present_d[hdl_q] = 1'b1;
        rs_d             = STAT_DONE;
        state_d          = ST_RESP;
      end

      ST_REMOVE: begin
        found_d = found_q || (rd_q.hdl == hdl_q);
        if (found_q) begin
          mem_we    = 1'b1;
          mem_waddr = jm1[IdxW-1:0];
          mem_wdata = rd_q;
        end
        if (j_q == cm1) begin
          cnt_d            = cm1;
          present_d[hdl_q] = 1'b0;
          if (kind_q == KIND_ADJUST) begin
            j_d = cm1;
            if (cm1 == '0) begin
              state_d = ST_INS_PUT;
            end else begin
              // if the handle was found earlier, the entry moving into the new tail is already in rd_q
              mem_re    = !found_q;
              mem_raddr = cm2[IdxW-1:0];
              state_d   = ST_INS_CMP;
            end
          end else begin
            rs_d    = STAT_DONE;
            state_d = ST_RESP;
          end
        end else begin
          j_d       = jp1;
          mem_re    = 1'b1;
          mem_raddr = jp1[IdxW-1:0];
        end
      end

      ST_TICK: begin
        if (!(pop_q && rd_q.tm <= now_q && pend_q && !can_emit)) begin
          if (pop_q && rd_q.tm <= now_q) begin
            // expired entry: hold it back until the next one tells us about last
            if (pend_q) begin
              ov_d = 1'b1;
              os_d = STAT_EXPIRED;
              oh_d = pend_h_q;
              ol_d = 1'b0;
            end
            pend_d               = 1'b1;
            pend_h_d             = rd_q.hdl;
            present_d[rd_q.hdl]  = 1'b0;
            n_d                  = n_q + 1'b1;
          end else begin
            pop_d     = 1'b0;
            mem_we    = 1'b1;
            mem_waddr = shift_at[IdxW-1:0];
            mem_wdata = rd_q;
          end
          if (j_q == cm1) begin
            state_d = ST_TICK_END;
          end else begin
            j_d       = jp1;
            mem_re    = 1'b1;
            mem_raddr = jp1[IdxW-1:0];
          end
        end
      end

      ST_TICK_END: begin
        cnt_d = cnt_q - n_q;
        if (pend_q) begin
          rs_d = STAT_EXPIRED;
          rh_d = pend_h_q;
        end else begin
          rs_d = STAT_NONE;
          rh_d = '0;
        end
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (can_emit) begin
          ov_d    = 1'b1;
          os_d    = rs_q;
          oh_d    = rh_q;
          ol_d    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = ov_q;
  assign status_o         = os_q;
  assign expired_handle_o = oh_q;
  assign last_o           = ol_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count exceeds depth");

  a_flags_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ($countones(present_q) == int'(cnt_q)))
    else $error("present flags disagree with entry count");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STAT_EXPIRED) |-> last_o)
    else $error("status result without last");

  a_resp_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && can_emit) |=> (out_valid_o && last_o))
    else $error("final result not presented");
`endif

endmodule
